/* hdl/rsi_pkg.sv */
// Shared widths, latencies and register codes for the ray/sphere intersection pipeline.
// No dependencies; the top level and the testbench import it, the other modules name it for defaults.
package rsi_pkg;

  localparam int IN_W    = 32;
  localparam int EPS_W   = 16;
  localparam int RAD_W   = 31;
  localparam int P_W     = IN_W + 1;
  localparam int A_W     = 66;
  localparam int H_W     = 68;
  localparam int C_W     = 68;
  localparam int HH_W    = 2 * H_W;
  localparam int AC_W    = A_W + C_W;
  localparam int DISC_W  = HH_W;
  localparam int SQ_DISC_W = 130;
  localparam int FRAC2_W = 32;
  localparam int SQ_IN_W = SQ_DISC_W + FRAC2_W;
  localparam int RT_W    = SQ_IN_W / 2;
  localparam int NUM_W   = 84;
  localparam int T_W     = NUM_W + 1;
  localparam int DIVISOR_W = 64;
  localparam int TD_W    = T_W + IN_W;
  localparam int OFS_W   = TD_W;

  localparam int MUL_LAT = 3;
  localparam int SQ_LAT  = RT_W;
  localparam int DIV_LAT = NUM_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int IN_BUS_W   = 7 * IN_W;
  localparam int OUT_BUS_W  = 4 * IN_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(65536);
  localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_EPSILON  = 3'd4
  } cfg_reg_t;

endpackage

/* hdl/rsi_delay.sv */
// Shift line that carries a valid bit and a sideband word alongside a pipelined unit.
// Depends on rsi_pkg for the default depth; the valid line is cleared by reset.
module rsi_delay #(
  parameter int W = 8,
  parameter int N = rsi_pkg::MUL_LAT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [N-1:0] vq;
  logic [W-1:0] dq [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq[0] <= vin;
      for (int k = 1; k < N; k++) vq[k] <= vq[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0] <= din;
      for (int k = 1; k < N; k++) dq[k] <= dq[k-1];
    end
  end

  assign vout = vq[N-1];
  assign dout = dq[N-1];

endmodule

/* hdl/rsi_mul.sv */
// Signed wide multiplier in three stages: magnitude, 32x32 partial products, sum and sign.
// Depends on rsi_pkg for the default widths.
module rsi_mul #(
  parameter int AW = rsi_pkg::IN_W,
  parameter int BW = rsi_pkg::IN_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW = AW + BW;
  localparam int LA = (AW + 31) / 32;
  localparam int LB = (BW + 31) / 32;
  localparam int XA = LA * 32;
  localparam int XB = LB * 32;

  logic [AW-1:0] abs_a;
  logic [BW-1:0] abs_b;
  logic [XA-1:0] ma;
  logic [XB-1:0] mb;
  logic          sg1, sg2;
  logic [63:0]   pp [LA][LB];
  logic [PW-1:0] acc;

  assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
  assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

  always_comb begin
    acc = '0;
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        acc = acc + (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma  <= XA'(abs_a);
      mb  <= XB'(abs_b);
      sg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp[i][j] <= ma[32*i +: 32] * mb[32*j +: 32];
        end
      end
      sg2 <= sg1;
      p   <= sg2 ? $signed(~acc + 1'b1) : $signed(acc);
    end
  end

endmodule

/* hdl/rsi_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Depends on rsi_pkg for the default radicand width.
module rsi_sqrt #(
  parameter int NW = rsi_pkg::SQ_IN_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   rad,
  output logic [NW/2-1:0] root
);

  localparam int RW = NW / 2;
  localparam int MW = RW + 2;

  logic [MW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [NW-1:0] rad_q  [RW];
  logic [MW-1:0] rem_d  [RW];
  logic [RW-1:0] root_d [RW];
  logic [NW-1:0] rad_d  [RW];

  always_comb begin
    logic [MW-1:0] rp, sh, tr;
    logic [RW-1:0] op;
    logic [NW-1:0] dp;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rp = '0;
        op = '0;
        dp = rad;
      end else begin
        rp = rem_q[k-1];
        op = root_q[k-1];
        dp = rad_q[k-1];
      end
      sh = {rp[RW-1:0], dp[NW-1 -: 2]};
      tr = {op, 2'b01};
      if (sh >= tr) begin
        rem_d[k]  = sh - tr;
        root_d[k] = {op[RW-2:0], 1'b1};
      end else begin
        rem_d[k]  = sh;
        root_d[k] = {op[RW-2:0], 1'b0};
      end
      rad_d[k] = dp << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

/* hdl/rsi_div.sv */
// Pipelined floor division of a signed numerator by a positive divisor, one quotient
// bit per stage. Depends on rsi_pkg for the default widths.
module rsi_div #(
  parameter int NW = rsi_pkg::NUM_W,
  parameter int DW = rsi_pkg::DIVISOR_W
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]       den,
  output logic signed [NW:0]  quot
);

  logic [NW-1:0] mag0;
  logic          neg0;
  logic [DW-1:0] den0;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] q_q   [NW];
  logic [NW-1:0] mag_q [NW];
  logic          neg_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] q_d   [NW];
  logic [NW-1:0] mag_d [NW];
  logic [NW:0]   qr;

  always_comb begin
    logic [DW-1:0] rp, dp;
    logic [NW-1:0] qp, mp;
    logic [DW:0]   sh;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        rp = '0;
        qp = '0;
        mp = mag0;
        dp = den0;
      end else begin
        rp = rem_q[k-1];
        qp = q_q[k-1];
        mp = mag_q[k-1];
        dp = den_q[k-1];
      end
      sh = {rp, mp[NW-1]};
      if (sh >= {1'b0, dp}) begin
        rem_d[k] = DW'(sh - {1'b0, dp});
        q_d[k]   = {qp[NW-2:0], 1'b1};
      end else begin
        rem_d[k] = DW'(sh);
        q_d[k]   = {qp[NW-2:0], 1'b0};
      end
      mag_d[k] = mp << 1;
    end
  end

  assign qr = {1'b0, q_q[NW-1]} + {{NW{1'b0}}, |rem_q[NW-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= num[NW-1] ? NW'(-num) : NW'(num);
      neg0 <= num[NW-1];
      den0 <= den;
      for (int k = 0; k < NW; k++) begin
        rem_q[k] <= rem_d[k];
        q_q[k]   <= q_d[k];
        mag_q[k] <= mag_d[k];
        neg_q[k] <= (k == 0) ? neg0 : neg_q[k-1];
        den_q[k] <= (k == 0) ? den0 : den_q[k-1];
      end
      quot <= neg_q[NW-1] ? $signed(~qr + 1'b1) : $signed({1'b0, q_q[NW-1]});
    end
  end

endmodule

/* hdl/ray_sphere_intersect.sv */
// Ray / sphere intersection, signed Q16.16 throughout; uses rsi_pkg, rsi_mul, rsi_sqrt,
// rsi_div and rsi_delay. The longest units are the 81-stage square root and the
// 86-stage dividers. Throughput: one ray per cycle while the output accepts words;
// a ray with two hits holds the pipeline while its second word leaves. Reset clears
// all valid bits and loads the register reset values; there is no clearing pass.
module ray_sphere_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::IN_W-1:0]       cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance
  input  logic [rsi_pkg::IN_BUS_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit_param, offset_x, offset_y, offset_z
  output logic [rsi_pkg::OUT_BUS_W-1:0]  m_axis_tdata,
  // hit_valid
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  import rsi_pkg::*;

  typedef struct packed {
    logic [2:0][P_W-1:0]  p;
    logic [2:0][IN_W-1:0] d;
    logic [IN_W-1:0]      lim;
  } ray_sb_t;

  typedef struct packed {
    ray_sb_t        ray;
    logic [A_W-1:0] a;
    logic [H_W-1:0] h;
    logic           ex1;
    logic           ex2;
  } full_sb_t;

  typedef struct packed {
    logic [2:0][P_W-1:0] p;
    logic [T_W-1:0]      t1;
    logic [T_W-1:0]      t2;
    logic                k1;
    logic                k2;
  } tail_sb_t;

  typedef struct packed {
    logic                 hit;
    logic [2:0][IN_W-1:0] off;
    logic [IN_W-1:0]      param;
  } res_t;

  localparam int RAY_SB_W  = $bits(ray_sb_t);
  localparam int FULL_SB_W = $bits(full_sb_t);
  localparam int TAIL_SB_W = $bits(tail_sb_t);

  function automatic logic [IN_W-1:0] sat32(input logic signed [OFS_W-1:0] x);
    logic [OFS_W-IN_W:0] hi;
    hi = x[OFS_W-1:IN_W-1];
    if (&hi || ~|hi) return x[IN_W-1:0];
    return x[OFS_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic root_ok(input logic signed [T_W-1:0] t,
                                   input logic signed [IN_W-1:0] lim,
                                   input logic [EPS_W-1:0] e);
    logic signed [T_W:0] te, le, ee, df;
    te = (T_W+1)'(t);
    le = (T_W+1)'(lim);
    ee = $signed((T_W+1)'(e));
    df = le - te;
    return !(te < ee) && !(le > 0 && (te > le || df < ee));
  endfunction

  // configuration
  logic signed [IN_W-1:0] cen [3];
  logic [RAD_W-1:0]       radius;
  logic [EPS_W-1:0]       eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen[0] <= '0;
      cen[1] <= '0;
      cen[2] <= '0;
      radius <= RADIUS_RESET;
      eps    <= EPSILON_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cen[0] <= $signed(cfg_data);
        REG_CENTER_Y: cen[1] <= $signed(cfg_data);
        REG_CENTER_Z: cen[2] <= $signed(cfg_data);
        REG_RADIUS:   radius <= cfg_data[RAD_W-1:0];
        REG_EPSILON:  eps    <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;

  // pipeline registers
  logic                   v1, v2, v6, v10, v92, vk, vo;
  logic [IN_W-1:0]        o1 [3];
  logic [IN_W-1:0]        d1 [3];
  logic [IN_W-1:0]        lim1;
  ray_sb_t                ray2;
  full_sb_t               full6;
  logic signed [C_W-1:0]  c6;
  full_sb_t               full10;
  logic signed [DISC_W-1:0] disc10;
  full_sb_t               full92;
  logic signed [NUM_W-1:0] n1, n2;
  ray_sb_t                rayk;
  logic signed [T_W-1:0]  t1k, t2k;
  logic                   k1k, k2k;
  res_t                   so_r0, so_r1;
  logic                   so_two;

  // unit outputs and delayed sideband
  logic                   v5, v9, v91, v178, v182;
  ray_sb_t                ray5;
  full_sb_t               full9, full91, full178, fl10;
  tail_sb_t               tail182, tailk;
  logic signed [63:0]     dd [3];
  logic signed [64:0]     pd [3];
  logic signed [65:0]     pq [3];
  logic signed [63:0]     rr;
  logic signed [HH_W-1:0] hh;
  logic signed [AC_W-1:0] ac;
  logic [RT_W-1:0]        root91;
  logic signed [T_W-1:0]  t1d, t2d;
  logic signed [TD_W-1:0] prod1 [3];
  logic signed [TD_W-1:0] prod2 [3];
  logic signed [NUM_W-1:0] hq, sq;
  res_t                   r1, r2, res0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v6  <= 1'b0;
      v10 <= 1'b0;
      v92 <= 1'b0;
      vk  <= 1'b0;
      vo  <= 1'b0;
    end else if (en) begin
      v1  <= s_axis_tvalid;
      v2  <= v1;
      v6  <= v5;
      v10 <= v9;
      v92 <= v91;
      vk  <= v178;
      vo  <= v182;
    end
  end

  assign hq = NUM_W'($signed(full91.h)) <<< 16;
  assign sq = $signed(NUM_W'(root91));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        o1[g] <= s_axis_tdata[IN_W*g +: IN_W];
        d1[g] <= s_axis_tdata[IN_W*(g+3) +: IN_W];
        ray2.p[g] <= P_W'($signed(o1[g])) - P_W'(cen[g]);
        ray2.d[g] <= d1[g];
      end
      lim1     <= s_axis_tdata[IN_W*6 +: IN_W];
      ray2.lim <= lim1;

      full6.ray <= ray5;
      full6.a   <= A_W'(dd[0]) + A_W'(dd[1]) + A_W'(dd[2]);
      full6.h   <= H_W'(pd[0]) + H_W'(pd[1]) + H_W'(pd[2]);
      full6.ex1 <= 1'b0;
      full6.ex2 <= 1'b0;
      c6        <= C_W'(pq[0]) + C_W'(pq[1]) + C_W'(pq[2]) - C_W'(rr);

      full10 <= full9;
      disc10 <= hh - DISC_W'(ac);

      full92 <= full91;
      n1     <= sq - hq;
      n2     <= -hq - sq;

      rayk <= full178.ray;
      t1k  <= t1d;
      t2k  <= t2d;
      k1k  <= full178.ex1 && root_ok(t1d, $signed(full178.ray.lim), eps);
      k2k  <= full178.ex2 && root_ok(t2d, $signed(full178.ray.lim), eps);

      so_r0  <= res0;
      so_r1  <= r2;
      so_two <= tail182.k1 && tail182.k2;
    end
  end

  // first products: d.d, p.d, p.p and r*r
  for (genvar g = 0; g < 3; g++) begin : g_bank1
    rsi_mul #(.AW(IN_W), .BW(IN_W)) u_dd (
      .clk(clk), .en(en), .a($signed(ray2.d[g])), .b($signed(ray2.d[g])), .p(dd[g]));
    rsi_mul #(.AW(P_W), .BW(IN_W)) u_pd (
      .clk(clk), .en(en), .a($signed(ray2.p[g])), .b($signed(ray2.d[g])), .p(pd[g]));
    rsi_mul #(.AW(P_W), .BW(P_W)) u_pp (
      .clk(clk), .en(en), .a($signed(ray2.p[g])), .b($signed(ray2.p[g])), .p(pq[g]));
  end

  rsi_mul #(.AW(IN_W), .BW(IN_W)) u_rr (
    .clk(clk), .en(en), .a($signed({1'b0, radius})), .b($signed({1'b0, radius})), .p(rr));

  rsi_delay #(.W(RAY_SB_W), .N(MUL_LAT)) u_dly1 (
    .clk(clk), .rst(rst), .en(en), .vin(v2), .din(ray2), .vout(v5), .dout(ray5));

  // discriminant products
  rsi_mul #(.AW(H_W), .BW(H_W)) u_hh (
    .clk(clk), .en(en), .a($signed(full6.h)), .b($signed(full6.h)), .p(hh));
  rsi_mul #(.AW(A_W), .BW(C_W)) u_ac (
    .clk(clk), .en(en), .a($signed(full6.a)), .b(c6), .p(ac));

  rsi_delay #(.W(FULL_SB_W), .N(MUL_LAT)) u_dly2 (
    .clk(clk), .rst(rst), .en(en), .vin(v6), .din(full6), .vout(v9), .dout(full9));

  // root existence travels with the square root
  always_comb begin
    fl10     = full10;
    fl10.ex1 = (full10.a != '0) && !disc10[DISC_W-1];
    fl10.ex2 = fl10.ex1 && (disc10 != '0);
  end

  rsi_sqrt #(.NW(SQ_IN_W)) u_sqrt (
    .clk(clk), .en(en), .rad({disc10[SQ_DISC_W-1:0], {FRAC2_W{1'b0}}}), .root(root91));

  rsi_delay #(.W(FULL_SB_W), .N(SQ_LAT)) u_dly3 (
    .clk(clk), .rst(rst), .en(en), .vin(v10), .din(fl10), .vout(v91), .dout(full91));

  // roots
  rsi_div #(.NW(NUM_W), .DW(DIVISOR_W)) u_div1 (
    .clk(clk), .en(en), .num(n1), .den(full92.a[DIVISOR_W-1:0]), .quot(t1d));
  rsi_div #(.NW(NUM_W), .DW(DIVISOR_W)) u_div2 (
    .clk(clk), .en(en), .num(n2), .den(full92.a[DIVISOR_W-1:0]), .quot(t2d));

  rsi_delay #(.W(FULL_SB_W), .N(DIV_LAT)) u_dly4 (
    .clk(clk), .rst(rst), .en(en), .vin(v92), .din(full92), .vout(v178), .dout(full178));

  // hit offsets
  for (genvar g = 0; g < 3; g++) begin : g_bank3
    rsi_mul #(.AW(T_W), .BW(IN_W)) u_td1 (
      .clk(clk), .en(en), .a(t1k), .b($signed(rayk.d[g])), .p(prod1[g]));
    rsi_mul #(.AW(T_W), .BW(IN_W)) u_td2 (
      .clk(clk), .en(en), .a(t2k), .b($signed(rayk.d[g])), .p(prod2[g]));
  end

  always_comb begin
    tailk.p  = rayk.p;
    tailk.t1 = t1k;
    tailk.t2 = t2k;
    tailk.k1 = k1k;
    tailk.k2 = k2k;
  end

  rsi_delay #(.W(TAIL_SB_W), .N(MUL_LAT)) u_dly5 (
    .clk(clk), .rst(rst), .en(en), .vin(vk), .din(tailk), .vout(v182), .dout(tail182));

  always_comb begin
    r1.hit   = 1'b1;
    r2.hit   = 1'b1;
    r1.param = sat32(OFS_W'($signed(tail182.t1)));
    r2.param = sat32(OFS_W'($signed(tail182.t2)));
    for (int g = 0; g < 3; g++) begin
      r1.off[g] = sat32(OFS_W'($signed(tail182.p[g])) + (prod1[g] >>> 16));
      r2.off[g] = sat32(OFS_W'($signed(tail182.p[g])) + (prod2[g] >>> 16));
    end
    if (tail182.k1)      res0 = r1;
    else if (tail182.k2) res0 = r2;
    else                 res0 = '0;
  end

  // output word and second-hit holding register
  logic o_valid, pend_valid, o_last;
  res_t o_res, pend;

  assign en = !pend_valid && (!o_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (m_axis_tready) pend_valid <= 1'b0;
    end else if (en) begin
      o_valid    <= vo;
      pend_valid <= vo && so_two;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      if (m_axis_tready) begin
        o_res  <= pend;
        o_last <= 1'b1;
      end
    end else if (en && vo) begin
      o_res  <= so_r0;
      o_last <= !so_two;
      pend   <= so_r1;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_res.off, o_res.param};
  assign m_axis_tuser  = o_res.hit;
  assign m_axis_tlast  = o_last;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for ray_sphere_intersect: queued rays drive the input stream,
// an exact wide-integer predictor fills a queue of due hits that the monitor checks.
// Depends on rsi_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import rsi_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, lim;
  } ray_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] param, ofs_x, ofs_y, ofs_z;
    logic               last;
  } hit_t;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IN_W-1:0]      cfg_data = '0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [IN_BUS_W-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [OUT_BUS_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  ray_t rays_pending[$];
  hit_t hits_due[$];
  ray_t ray_on_bus;
  int   errors = 0;
  int   cycles = 0;
  bit   calm = 0;
  bit   hold_req = 0;
  int   hold_cnt = 0;

  logic signed [31:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
  logic [30:0]        sph_rad = 31'd65536;
  logic [15:0]        sph_eps = 16'd1;

  ray_sphere_intersect dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [255:0] isqrt(logic [255:0] num);
    logic [255:0] res, b;
    res = 0;
    b = 256'd1 << 254;
    for (int i = 0; i < 128; i++) begin
      if (num >= res + b) begin
        num = num - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t x);
    wide_t hi, lo;
    hi = 2147483647;
    lo = -hi - 1;
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[31:0];
  endfunction

  task automatic predict_hits(ray_t r);
    wide_t p[3], d[3], a, h, c, disc, s, h16, t, lim, eps, rr;
    wide_t roots[2];
    hit_t  out[2];
    int    n, cnt;
    p[0] = wide_t'(r.ox) - wide_t'(sph_cx);
    p[1] = wide_t'(r.oy) - wide_t'(sph_cy);
    p[2] = wide_t'(r.oz) - wide_t'(sph_cz);
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    rr = {225'd0, sph_rad};
    eps = {240'd0, sph_eps};
    lim = r.lim;
    a = 0; h = 0; c = -(rr * rr);
    n = 0; cnt = 0;
    for (int i = 0; i < 3; i++) begin
      a = a + d[i] * d[i];
      h = h + p[i] * d[i];
      c = c + p[i] * p[i];
    end
    if (a != 0) begin
      disc = h * h - a * c;
      if (disc >= 0) begin
        s = isqrt(disc <<< 32);
        h16 = -(h <<< 16);
        roots[n] = floor_div(h16 + s, a);
        n++;
        if (disc != 0) begin
          roots[n] = floor_div(h16 - s, a);
          n++;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      t = roots[k];
      if (t < 0 || t < eps) continue;
      if (lim > 0 && (t > lim || lim - t < eps)) continue;
      out[cnt].valid = 1;
      out[cnt].param = clamp32(t);
      out[cnt].ofs_x = clamp32(p[0] + ((t * d[0]) >>> 16));
      out[cnt].ofs_y = clamp32(p[1] + ((t * d[1]) >>> 16));
      out[cnt].ofs_z = clamp32(p[2] + ((t * d[2]) >>> 16));
      out[cnt].last = 0;
      cnt++;
    end
    if (cnt == 0) begin
      out[0] = '0;
      cnt = 1;
    end
    out[cnt-1].last = 1;
    for (int k = 0; k < cnt; k++) hits_due.push_back(out[k]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_hits(ray_on_bus);
      if (rays_pending.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
        ray_on_bus = rays_pending.pop_front();
        s_axis_tdata <= {ray_on_bus.lim, ray_on_bus.dz, ray_on_bus.dy, ray_on_bus.dx,
                         ray_on_bus.oz, ray_on_bus.oy, ray_on_bus.ox};
        s_axis_tvalid <= 1;
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    hit_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tlast};
        if (hits_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", got);
        end else begin
          want = hits_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected v=%0d t=%h o=%h %h %h l=%0d",
                       want.valid, want.param, want.ofs_x, want.ofs_y, want.ofs_z, want.last);
              $display("          got      v=%0d t=%h o=%h %h %h l=%0d",
                       got.valid, got.param, got.ofs_x, got.ofs_y, got.ofs_z, got.last);
            end
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 600;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= calm || $urandom_range(99) >= 28;
      end
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    case (idx)
      REG_CENTER_X: sph_cx = val;
      REG_CENTER_Y: sph_cy = val;
      REG_CENTER_Z: sph_cz = val;
      REG_RADIUS:   sph_rad = val[30:0];
      REG_EPSILON:  sph_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r,
                            logic [31:0] e);
    cfg_write(REG_CENTER_X, x);
    cfg_write(REG_CENTER_Y, y);
    cfg_write(REG_CENTER_Z, z);
    cfg_write(REG_RADIUS, r);
    cfg_write(REG_EPSILON, e);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (rays_pending.size() > 0 || s_axis_tvalid || hits_due.size() > 0);
    repeat (200) @(negedge clk);
  endtask

  function automatic ray_t rand_ray();
    ray_t r;
    int   rad, k, sh;
    logic signed [31:0] off[3];
    rad = (sph_rad > 31'd2097152) ? 2097152 : int'(sph_rad) + 1;
    k = $urandom_range(99);
    if (k < 60) begin
      for (int i = 0; i < 3; i++) off[i] = $urandom_range(0, 6 * rad) - 3 * rad;
      r.ox = sph_cx + off[0];
      r.oy = sph_cy + off[1];
      r.oz = sph_cz + off[2];
      sh = $urandom_range(0, 3);
      r.dx = (-off[0] + $signed($urandom_range(0, rad)) - rad / 2) >>> sh;
      r.dy = (-off[1] + $signed($urandom_range(0, rad)) - rad / 2) >>> sh;
      r.dz = (-off[2] + $signed($urandom_range(0, rad)) - rad / 2) >>> sh;
    end else if (k < 80) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (k < 90) begin
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = 0; r.dy = 0; r.dz = 0;
    end else begin
      r.ox = sph_cx + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      r.oy = sph_cy + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      r.oz = sph_cz + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      r.dx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      r.dy = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      r.dz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    end
    k = $urandom_range(99);
    if (k < 40) r.lim = 0;
    else if (k < 55) r.lim = -$signed($urandom_range(1, 32'h7fffffff));
    else if (k < 95) r.lim = $urandom_range(1, 8 << 16);
    else r.lim = $urandom;
    return r;
  endfunction

  task automatic push_random(int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) rays_pending.push_back(rand_ray());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    // unit sphere at origin, default registers
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd196608});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd65536, -32'sd131072});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd196608, -32'sd131072});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0,
                            32'sd0, 32'sd0, 32'sd0});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, 32'sd0});
    rays_pending.push_back({32'sd131072, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd196608});
    rays_pending.push_back({32'sd196608, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd196608});
    rays_pending.push_back({32'sd131073, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd196608});
    rays_pending.push_back({-32'sd5, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd196608});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd1,
                            32'sd0, 32'sd0, -32'sd65536});
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, 32'sd65535});
    rays_pending.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    rays_pending.push_back({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000});
    rays_pending.push_back({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h7fffffff});
    rays_pending.push_back({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                            32'hffffffff, 32'hffffffff, 32'hffffffff});
    rays_pending.push_back({32'h80000000, 32'sd0, 32'sd0, 32'h7fffffff,
                            32'sd0, 32'sd0, 32'sd0});
    drain();
    set_sphere(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'd0);
    @(negedge clk);
    rays_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, 32'sd0});
    rays_pending.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd65536,
                            32'sd0, 32'sd0, -32'sd65536});
    push_random(200);
    drain();
    set_sphere(32'sd1 << 20, -(32'sd3 << 18), 32'sd12345, 32'sd1 << 18, 32'd300);
    calm = 1;
    push_random(150);
    drain();
    calm = 0;
    set_sphere($urandom, $urandom, $urandom, $urandom_range(1 << 14, 1 << 21),
               $urandom_range(0, 16));
    push_random(250);
    @(negedge clk);
    hold_req = 1;
    drain();
    set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffff);
    push_random(100);
    drain();
    set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'd0, 32'hffff);
    push_random(60);
    drain();
    set_sphere($urandom, $urandom, $urandom, $urandom_range(1 << 12, 1 << 20),
               $urandom_range(0, 65535));
    push_random(120);
    drain();
    set_sphere($urandom_range(0, 1 << 20), 32'sd0, -32'sd65536, 32'sd1 << 17, 32'd1);
    push_random(150);
    drain();
    if (errors == 0 && hits_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
